// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/slhm_pkg.sv -----
// ----------------------------------------------------------------------------
// slhm_pkg
// types and constants of the storage latency histogram monitor
// ----------------------------------------------------------------------------
package slhm_pkg;

   // request modes
   localparam logic [1:0] MODE_BEGIN   = 2'd0;
   localparam logic [1:0] MODE_END     = 2'd1;
   localparam logic [1:0] MODE_COUNTER = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   // record kinds
   localparam logic [2:0] KIND_WAKE      = 3'd0;
   localparam logic [2:0] KIND_RD_BEGIN  = 3'd1;
   localparam logic [2:0] KIND_WR_BEGIN  = 3'd2;
   localparam logic [2:0] KIND_RD_END    = 3'd3;
   localparam logic [2:0] KIND_WR_END    = 3'd4;
   localparam logic [2:0] KIND_COUNTER   = 3'd5;

   // scalar counter numbers
   localparam int NUM_SCALARS = 10;
   localparam logic [3:0] SC_RD_CNT   = 4'd0;
   localparam logic [3:0] SC_WR_CNT   = 4'd1;
   localparam logic [3:0] SC_WAKE_CNT = 4'd2;
   localparam logic [3:0] SC_WAKE_MAX = 4'd3;
   localparam logic [3:0] SC_RD_MAX   = 4'd4;
   localparam logic [3:0] SC_WR_MAX   = 4'd5;
   localparam logic [3:0] SC_RD_SEQ   = 4'd6;
   localparam logic [3:0] SC_RD_DIS   = 4'd7;
   localparam logic [3:0] SC_WR_SEQ   = 4'd8;
   localparam logic [3:0] SC_WR_DIS   = 4'd9;

   localparam logic [31:0] WAKE_GAP_RESET = 32'd100;

   localparam int REQ_DATA_W = 144;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USER_W = 3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  drive;
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
      logic        last;
   } slhm_result_type;

   // position of the highest set bit, zero for zero
   function automatic logic [4:0] msb_pos(input logic [31:0] t);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (t[i]) p = 5'(i);
      end
      return p;
   endfunction

endpackage

// ----- src/storage_latency_histogram_monitor_core.sv -----
// ----------------------------------------------------------------------------
// storage_latency_histogram_monitor_core
// request begin/end monitor with log2 latency histograms and counters
// ----------------------------------------------------------------------------
// channel  direction  tdata                          tuser
// req      in         drive..counter_index           mode, is_write
// rsp      out        drive_out, word_a..word_c      record_kind (tlast = last)
// csr      in         wake_gap_threshold write       -
//
// a request first reads the histogram ram, then updates counters, writes the
// bucket back and queues the results.
// a begin that wakes the drive queues two results, all others one or none.
// reset clears the scalars directly and the histograms via the ram valid bits.
// requests stall while busy or while the result queue holds over two results.
// ----------------------------------------------------------------------------
module storage_latency_histogram_monitor_core #(
   parameter int HIST_BUCKETS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // drive[7:0] start_lba[55:8] block_count[71:56] status_code[103:72]
   // now[135:104] counter_index[141:136] zero[143:142]
   input  logic [slhm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode[1:0] is_write[2]
   input  logic [slhm_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // drive_out[7:0] word_a[39:8] word_b[71:40] word_c[103:72]
   output logic [slhm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // record_kind[2:0]
   output logic [slhm_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [31:0]                       csr_wr_data
);
   import slhm_pkg::*;

   localparam int MEM_DEPTH = 2 * HIST_BUCKETS;
   localparam int HIST_AW   = $clog2(MEM_DEPTH);
   localparam int BIN_W     = $clog2(HIST_BUCKETS);
   localparam logic [4:0] POS_MAX = 5'(HIST_BUCKETS - 1);

   typedef struct packed {
      logic [1:0]         mode;
      logic               wr;
      logic [7:0]         drive;
      logic [47:0]        start;
      logic [15:0]        count;
      logic [31:0]        status;
      logic [31:0]        now;
      logic [5:0]         idx;
      logic [31:0]        elapsed;
      logic [HIST_AW-1:0] bin_addr;
   } stage_type;

   // request unpack
   logic [1:0]  in_mode;
   logic        in_wr;
   logic [31:0] in_now;
   logic [5:0]  in_idx;
   logic        accept;

   assign in_mode = req_tuser[1:0];
   assign in_wr   = req_tuser[2];
   assign in_now  = req_tdata[135:104];
   assign in_idx  = req_tdata[141:136];

   // state
   logic        busy_ff, busy_in;
   stage_type   st_ff;
   logic [31:0] thresh_ff, thresh_in;
   logic [31:0] rd_begin_ff, rd_begin_in;
   logic [31:0] wr_begin_ff, wr_begin_in;
   logic [31:0] last_end_ff, last_end_in;
   logic [48:0] rd_next_ff, rd_next_in;
   logic [48:0] wr_next_ff, wr_next_in;
   logic        seen_any_ff, seen_any_in;
   logic        seen_rd_ff, seen_rd_in;
   logic        seen_wr_ff, seen_wr_in;
   logic [31:0] scalar_ff [NUM_SCALARS];
   logic [31:0] scalar_in [NUM_SCALARS];

   logic fifo_room;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !busy_ff && fifo_room;

   // first step: elapsed time, bucket and ram address
   logic [31:0]        acc_elapsed;
   logic [4:0]         acc_pos;
   logic [BIN_W-1:0]   acc_bin;
   logic [HIST_AW-1:0] acc_bin_addr;
   logic [6:0]         acc_off;
   logic [HIST_AW-1:0] rd_addr;

   always_comb begin
      acc_elapsed  = in_now - (in_wr ? wr_begin_ff : rd_begin_ff);
      acc_pos      = msb_pos(acc_elapsed);
      acc_bin      = (acc_pos > POS_MAX) ? BIN_W'(POS_MAX) : BIN_W'(acc_pos);
      acc_bin_addr = in_wr ? HIST_AW'(HIST_BUCKETS) + HIST_AW'(acc_bin)
                           : HIST_AW'(acc_bin);
      acc_off      = {1'b0, in_idx} - 7'(NUM_SCALARS);
      rd_addr      = (in_mode == MODE_END) ? acc_bin_addr : acc_off[HIST_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st_ff.mode     <= in_mode;
         st_ff.wr       <= in_wr;
         st_ff.drive    <= req_tdata[7:0];
         st_ff.start    <= req_tdata[55:8];
         st_ff.count    <= req_tdata[71:56];
         st_ff.status   <= req_tdata[103:72];
         st_ff.now      <= in_now;
         st_ff.idx      <= in_idx;
         st_ff.elapsed  <= acc_elapsed;
         st_ff.bin_addr <= acc_bin_addr;
      end
   end

   // histogram ram
   logic [31:0] hist_rdata;
   logic        hist_wr_en;

   assign hist_wr_en = busy_ff && (st_ff.mode == MODE_END);

   slhm_hist_mem #(
      .DEPTH (MEM_DEPTH),
      .AW    (HIST_AW)
   ) u_hist_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (hist_rdata),
      .wr_en   (hist_wr_en),
      .wr_addr (st_ff.bin_addr),
      .wr_data (hist_rdata + 32'd1)
   );

   // second step: counters and results
   logic [31:0]     gap;
   logic            wake;
   logic [6:0]      s_idx7;
   logic [6:0]      s_off;
   logic [48:0]     start49;
   logic [48:0]     next_lba;
   logic            seq;
   logic [31:0]     cnt_value;
   logic            push0_valid, push1_valid;
   slhm_result_type push0_data, push1_data;

   always_comb begin
      gap      = st_ff.now - last_end_ff;
      wake     = seen_any_ff && (gap > thresh_ff);
      s_idx7   = {1'b0, st_ff.idx};
      s_off    = s_idx7 - 7'(NUM_SCALARS);
      start49  = {1'b0, st_ff.start};
      next_lba = start49 + 49'(st_ff.count);
      seq      = start49 == (st_ff.wr ? wr_next_ff : rd_next_ff);

      if (s_idx7 < 7'(NUM_SCALARS)) begin
         cnt_value = scalar_ff[st_ff.idx[3:0]];
      end else if (s_off < 7'(MEM_DEPTH)) begin
         cnt_value = hist_rdata;
      end else begin
         cnt_value = 32'd0;
      end

      busy_in     = accept;
      thresh_in   = csr_wr_en ? csr_wr_data : thresh_ff;
      rd_begin_in = rd_begin_ff;
      wr_begin_in = wr_begin_ff;
      last_end_in = last_end_ff;
      rd_next_in  = rd_next_ff;
      wr_next_in  = wr_next_ff;
      seen_any_in = seen_any_ff;
      seen_rd_in  = seen_rd_ff;
      seen_wr_in  = seen_wr_ff;
      for (int i = 0; i < NUM_SCALARS; i++) scalar_in[i] = scalar_ff[i];

      push0_valid = 1'b0;
      push1_valid = 1'b0;
      push0_data  = '0;
      push1_data  = '0;

      if (busy_ff) begin
         unique case (st_ff.mode)
            MODE_BEGIN: begin
               if (st_ff.wr) wr_begin_in = st_ff.now;
               else rd_begin_in = st_ff.now;
               push0_valid = 1'b1;
               if (wake) begin
                  scalar_in[SC_WAKE_CNT] = scalar_ff[SC_WAKE_CNT] + 32'd1;
                  if (gap > scalar_ff[SC_WAKE_MAX]) scalar_in[SC_WAKE_MAX] = gap;
                  push0_data = '{KIND_WAKE, st_ff.drive, gap, st_ff.start[31:0],
                                 32'(st_ff.count), 1'b0};
                  push1_valid = 1'b1;
                  push1_data = '{st_ff.wr ? KIND_WR_BEGIN : KIND_RD_BEGIN, st_ff.drive,
                                 st_ff.start[31:0], 32'(st_ff.count), st_ff.now, 1'b1};
               end else begin
                  push0_data = '{st_ff.wr ? KIND_WR_BEGIN : KIND_RD_BEGIN, st_ff.drive,
                                 st_ff.start[31:0], 32'(st_ff.count), st_ff.now, 1'b1};
               end
            end
            MODE_END: begin
               if (st_ff.wr) begin
                  scalar_in[SC_WR_CNT] = scalar_ff[SC_WR_CNT] + 32'd1;
                  if (st_ff.elapsed > scalar_ff[SC_WR_MAX])
                     scalar_in[SC_WR_MAX] = st_ff.elapsed;
                  if (seen_wr_ff) begin
                     if (seq) scalar_in[SC_WR_SEQ] = scalar_ff[SC_WR_SEQ] + 32'd1;
                     else scalar_in[SC_WR_DIS] = scalar_ff[SC_WR_DIS] + 32'd1;
                  end
                  wr_next_in = next_lba;
                  seen_wr_in = 1'b1;
               end else begin
                  scalar_in[SC_RD_CNT] = scalar_ff[SC_RD_CNT] + 32'd1;
                  if (st_ff.elapsed > scalar_ff[SC_RD_MAX])
                     scalar_in[SC_RD_MAX] = st_ff.elapsed;
                  if (seen_rd_ff) begin
                     if (seq) scalar_in[SC_RD_SEQ] = scalar_ff[SC_RD_SEQ] + 32'd1;
                     else scalar_in[SC_RD_DIS] = scalar_ff[SC_RD_DIS] + 32'd1;
                  end
                  rd_next_in = next_lba;
                  seen_rd_in = 1'b1;
               end
               last_end_in = st_ff.now;
               seen_any_in = 1'b1;
               push0_valid = 1'b1;
               push0_data  = '{st_ff.wr ? KIND_WR_END : KIND_RD_END, st_ff.drive,
                               st_ff.start[31:0], st_ff.elapsed, st_ff.status, 1'b1};
            end
            MODE_COUNTER: begin
               push0_valid = 1'b1;
               push0_data  = '{KIND_COUNTER, 8'd0, cnt_value, 32'd0, 32'd0, 1'b1};
            end
            MODE_NONE: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         thresh_ff   <= WAKE_GAP_RESET;
         rd_begin_ff <= 32'd0;
         wr_begin_ff <= 32'd0;
         last_end_ff <= 32'd0;
         rd_next_ff  <= 49'd0;
         wr_next_ff  <= 49'd0;
         seen_any_ff <= 1'b0;
         seen_rd_ff  <= 1'b0;
         seen_wr_ff  <= 1'b0;
         for (int i = 0; i < NUM_SCALARS; i++) scalar_ff[i] <= 32'd0;
      end else begin
         busy_ff     <= busy_in;
         thresh_ff   <= thresh_in;
         rd_begin_ff <= rd_begin_in;
         wr_begin_ff <= wr_begin_in;
         last_end_ff <= last_end_in;
         rd_next_ff  <= rd_next_in;
         wr_next_ff  <= wr_next_in;
         seen_any_ff <= seen_any_in;
         seen_rd_ff  <= seen_rd_in;
         seen_wr_ff  <= seen_wr_in;
         for (int i = 0; i < NUM_SCALARS; i++) scalar_ff[i] <= scalar_in[i];
      end
   end

   // result queue
   slhm_result_type out_data;

   slhm_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .push0_valid (push0_valid),
      .push0_data  (push0_data),
      .push1_valid (push1_valid),
      .push1_data  (push1_data),
      .room        (fifo_room),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (out_data)
   );

   assign rsp_tdata = {out_data.word_c, out_data.word_b, out_data.word_a, out_data.drive};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;
endmodule

// ----- src/slhm_hist_mem.sv -----
// ----------------------------------------------------------------------------
// slhm_hist_mem
// histogram ram with registered read and per-entry valid bits
// ----------------------------------------------------------------------------
module slhm_hist_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data
);
   logic [31:0]      mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [31:0]      rdata_ff;
   logic             rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         if (rd_en) rvalid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : 32'd0;
endmodule

// ----- src/slhm_out_fifo.sv -----
// ----------------------------------------------------------------------------
// slhm_out_fifo
// four-entry result queue taking up to two results per cycle
// ----------------------------------------------------------------------------
module slhm_out_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push0_valid,
   input  slhm_pkg::slhm_result_type push0_data,
   input  logic                     push1_valid,
   input  slhm_pkg::slhm_result_type push1_data,
   output logic                     room,
   output logic                     out_valid,
   input  logic                     out_ready,
   output slhm_pkg::slhm_result_type out_data
);
   import slhm_pkg::*;

   slhm_result_type mem_ff [4];
   logic [1:0] wptr_ff, wptr_in;
   logic [1:0] rptr_ff, rptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [1:0] npush;

   assign pop   = out_valid && out_ready;
   assign npush = 2'(push0_valid) + 2'(push0_valid && push1_valid);

   always_comb begin
      wptr_in  = wptr_ff + npush;
      rptr_in  = rptr_ff + 2'(pop);
      count_in = count_ff + 3'(npush) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (push0_valid) mem_ff[wptr_ff] <= push0_data;
      if (push0_valid && push1_valid) mem_ff[wptr_ff + 2'd1] <= push1_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 2'd0;
         rptr_ff  <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // space for the two results one request can cause
   assign room      = count_ff <= 3'd2;
   assign out_valid = count_ff != 3'd0;
   assign out_data  = mem_ff[rptr_ff];
endmodule

// ----- src/slhm_checker.sv -----
// ----------------------------------------------------------------------------
// slhm_checker
// port-level checks of the latency histogram monitor, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slhm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [slhm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [slhm_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                            rsp_tlast
);
   import slhm_pkg::*;

   logic                             rsp_stall;
   logic [RSP_DATA_W+RSP_USER_W:0]   rsp_beat;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_beat  = {rsp_tlast, rsp_tuser, rsp_tdata};

   // no new request is taken while an accepted one is in progress
   `ASSERT_NEXT(a_two_cycle, clock, reset, req_tvalid && req_tready, !req_tready)

   // queue is empty right after reset
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // a wake record is never last: its begin record follows it
   `ASSERT_IMPLY(a_wake_not_last, clock, reset, rsp_tvalid && rsp_tuser == KIND_WAKE, !rsp_tlast)

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_beat))
endmodule

bind storage_latency_histogram_monitor_core slhm_checker u_slhm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- test/storage_latency_histogram_monitor_core_tb.sv -----
// ----------------------------------------------------------------------------
// storage_latency_histogram_monitor_core_tb
// drives begin, end, counter-read and dropped requests into the monitor core and
// checks every event record against a cycle-free model of the counters,
// histograms and wake detection, under several thresholds and stall mixes
// ----------------------------------------------------------------------------
module storage_latency_histogram_monitor_core_tb;
   import slhm_pkg::*;

   localparam int HIST_BUCKETS = 16;
   localparam int PHASE_ITEMS = 205;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [1:0]  mode;
      logic        wr;
      logic [7:0]  drive;
      logic [47:0] lba;
      logic [15:0] count;
      logic [31:0] status;
      logic [31:0] now;
      logic [5:0]  idx;
   } storage_request_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [REQ_USER_W-1:0]   req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_wr_en = 1'b0;
   logic [31:0]             csr_wr_data = '0;

   storage_latency_histogram_monitor_core #(
      .HIST_BUCKETS(HIST_BUCKETS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predicted monitor state, index 0 read side, 1 write side
   logic [31:0] wake_threshold = WAKE_GAP_RESET;
   logic [31:0] begin_tick [2];
   logic [31:0] last_end_tick;
   logic [48:0] next_lba [2];
   logic        dir_seen [2];
   logic        any_end_seen;
   logic [31:0] scalars [NUM_SCALARS];
   logic [31:0] latency_hist [2][HIST_BUCKETS];

   storage_request_type pending_requests [$];
   slhm_result_type     expected_records [$];
   storage_request_type in_flight;

   int unsigned queued_total = 0;
   int unsigned accepted_total = 0;
   int unsigned records_checked = 0;
   int unsigned wake_records = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned mode_tally [4];
   int unsigned settings_used = 1;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   // stimulus side timeline and lba continuity
   logic [31:0] stim_tick = 32'd1000;
   logic [48:0] stim_next_lba [2];

   initial begin
      for (int d = 0; d < 2; d++) begin
         begin_tick[d] = '0;
         next_lba[d] = '0;
         dir_seen[d] = 1'b0;
         stim_next_lba[d] = '0;
         for (int b = 0; b < HIST_BUCKETS; b++) latency_hist[d][b] = '0;
      end
      for (int s = 0; s < NUM_SCALARS; s++) scalars[s] = '0;
      for (int m = 0; m < 4; m++) mode_tally[m] = 0;
      last_end_tick = '0;
      any_end_seen = 1'b0;
   end

   function automatic int latency_bucket(input logic [31:0] t);
      int b;
      b = 0;
      for (int i = 1; i < HIST_BUCKETS; i++) begin
         if ({1'b0, t} >= (33'd1 << i)) b = i;
      end
      return b;
   endfunction

   function automatic logic [31:0] counter_value(input logic [5:0] idx);
      int i;
      i = idx;
      if (i < NUM_SCALARS) return scalars[i];
      i -= NUM_SCALARS;
      if (i < HIST_BUCKETS) return latency_hist[0][i];
      i -= HIST_BUCKETS;
      if (i < HIST_BUCKETS) return latency_hist[1][i];
      return '0;
   endfunction

   function automatic void add_record(input logic [2:0] kind, input logic [7:0] drv,
                                      input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c, input logic lst);
      slhm_result_type rec;
      rec.kind = kind;
      rec.drive = drv;
      rec.word_a = a;
      rec.word_b = b;
      rec.word_c = c;
      rec.last = lst;
      expected_records.push_back(rec);
   endfunction

   function automatic void predict_records(input storage_request_type r);
      logic [31:0] gap;
      logic [31:0] elapsed;
      logic [31:0] slo;
      logic [48:0] nxt;
      int          d;
      int          bkt;
      slo = r.lba[31:0];
      d = r.wr;
      case (r.mode)
         MODE_BEGIN: begin
            if (any_end_seen) begin
               gap = r.now - last_end_tick;
               if (gap > wake_threshold) begin
                  scalars[SC_WAKE_CNT] += 32'd1;
                  if (gap > scalars[SC_WAKE_MAX]) scalars[SC_WAKE_MAX] = gap;
                  add_record(KIND_WAKE, r.drive, gap, slo, {16'd0, r.count}, 1'b0);
                  wake_records++;
               end
            end
            begin_tick[d] = r.now;
            add_record(r.wr ? KIND_WR_BEGIN : KIND_RD_BEGIN, r.drive, slo,
                       {16'd0, r.count}, r.now, 1'b1);
         end
         MODE_END: begin
            elapsed = r.now - begin_tick[d];
            bkt = latency_bucket(elapsed);
            nxt = {1'b0, r.lba} + {33'd0, r.count};
            scalars[r.wr ? SC_WR_CNT : SC_RD_CNT] += 32'd1;
            latency_hist[d][bkt] += 32'd1;
            if (elapsed > scalars[r.wr ? SC_WR_MAX : SC_RD_MAX])
               scalars[r.wr ? SC_WR_MAX : SC_RD_MAX] = elapsed;
            // first end of a direction has nothing to be sequential to
            if (dir_seen[d]) begin
               if ({1'b0, r.lba} == next_lba[d])
                  scalars[r.wr ? SC_WR_SEQ : SC_RD_SEQ] += 32'd1;
               else
                  scalars[r.wr ? SC_WR_DIS : SC_RD_DIS] += 32'd1;
            end
            next_lba[d] = nxt;
            dir_seen[d] = 1'b1;
            last_end_tick = r.now;
            any_end_seen = 1'b1;
            add_record(r.wr ? KIND_WR_END : KIND_RD_END, r.drive, slo, elapsed,
                       r.status, 1'b1);
         end
         MODE_COUNTER: begin
            add_record(KIND_COUNTER, 8'd0, counter_value(r.idx), 32'd0, 32'd0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_records(in_flight);
            mode_tally[in_flight.mode]++;
            accepted_total++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = pending_requests.pop_front();
               req_tdata <= {2'b00, in_flight.idx, in_flight.now, in_flight.status,
                             in_flight.count, in_flight.lba, in_flight.drive};
               req_tuser <= {in_flight.wr, in_flight.mode};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // record monitor
   always @(posedge clock) begin : record_monitor
      slhm_result_type got;
      slhm_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.drive = rsp_tdata[7:0];
            got.word_a = rsp_tdata[39:8];
            got.word_b = rsp_tdata[71:40];
            got.word_c = rsp_tdata[103:72];
            got.last = rsp_tlast;
            if (expected_records.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("tb: unexpected record kind %0d drive %02h a %08h b %08h c %08h",
                           got.kind, got.drive, got.word_a, got.word_b, got.word_c);
            end else begin
               want = expected_records.pop_front();
               if (got.kind !== want.kind || got.drive !== want.drive ||
                   got.word_a !== want.word_a || got.word_b !== want.word_b ||
                   got.word_c !== want.word_c || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("tb: record %0d want kind %0d drive %02h a %08h b %08h c %08h last %0b",
                              records_checked, want.kind, want.drive, want.word_a,
                              want.word_b, want.word_c, want.last);
                     $display("tb: record %0d got  kind %0d drive %02h a %08h b %08h c %08h last %0b",
                              records_checked, got.kind, got.drive, got.word_a,
                              got.word_b, got.word_c, got.last);
                  end
               end
            end
            records_checked++;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic storage_request_type make_request(
      input logic [1:0] mode, input logic wr, input logic [7:0] drive,
      input logic [47:0] lba, input logic [15:0] count, input logic [31:0] status,
      input logic [31:0] now, input logic [5:0] idx);
      storage_request_type r;
      r.mode = mode;
      r.wr = wr;
      r.drive = drive;
      r.lba = lba;
      r.count = count;
      r.status = status;
      r.now = now;
      r.idx = idx;
      return r;
   endfunction

   function automatic storage_request_type scramble_request();
      storage_request_type r;
      r.mode = 2'($urandom);
      r.wr = 1'($urandom);
      r.drive = 8'($urandom);
      r.lba = 48'({$urandom, $urandom});
      r.count = 16'($urandom);
      r.status = $urandom;
      r.now = $urandom;
      r.idx = 6'($urandom);
      return r;
   endfunction

   // spans of every magnitude so that each histogram bucket gets hits
   function automatic logic [31:0] random_span();
      int sh;
      sh = $urandom_range(31);
      return $urandom >> (31 - sh);
   endfunction

   task automatic queue_request(input storage_request_type r);
      pending_requests.push_back(r);
      queued_total++;
   endtask

   task automatic queue_counter_read();
      storage_request_type r;
      r = scramble_request();
      r.mode = MODE_COUNTER;
      r.idx = ($urandom_range(99) < 85) ? 6'($urandom_range(41)) : 6'($urandom_range(63, 42));
      queue_request(r);
   endtask

   task automatic queue_random_traffic(input int n);
      int                  made;
      int                  pick;
      storage_request_type r;
      storage_request_type e;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(99);
         r = scramble_request();
         if (pick < 70) begin
            // well-formed begin/end pair, mostly continuing the last lba
            r.mode = MODE_BEGIN;
            if ($urandom_range(99) < 60) r.lba = stim_next_lba[r.wr][47:0];
            stim_tick += random_span();
            r.now = stim_tick;
            queue_request(r);
            e = r;
            e.mode = MODE_END;
            e.status = $urandom;
            stim_tick += random_span();
            e.now = stim_tick;
            stim_next_lba[e.wr] = {1'b0, e.lba} + {33'd0, e.count};
            made += 2;
            if ($urandom_range(99) < 15) begin
               queue_counter_read();
               made++;
            end
            queue_request(e);
         end else if (pick < 80) begin
            // lone begin or end, sometimes at an arbitrary tick
            r.mode = $urandom_range(1) ? MODE_END : MODE_BEGIN;
            if ($urandom_range(1)) begin
               stim_tick += random_span();
               r.now = stim_tick;
            end
            queue_request(r);
            made++;
         end else if (pick < 96) begin
            queue_counter_read();
            made++;
         end else begin
            r.mode = MODE_NONE;
            queue_request(r);
         end
      end
   endtask

   // every accepted request answered and the pipe given time to empty
   task automatic wait_idle();
      while (accepted_total != queued_total || expected_records.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      wake_threshold = value;
      settings_used++;
   endtask

   initial begin : stimulus
      logic [5:0]  read_list [14];
      logic [31:0] thresholds [5];
      int          send_mix [5];
      int          recv_mix [5];
      read_list = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10,
                    6'd25, 6'd41, 6'd42, 6'd63};
      thresholds[0] = 32'd0;
      thresholds[1] = 32'hFFFF_FFFF;
      thresholds[2] = $urandom_range(4096, 1);
      thresholds[3] = 32'd1 << $urandom_range(30, 8);
      thresholds[4] = $urandom;
      send_mix = '{0, 45, 0, 14, 0};
      recv_mix = '{0, 0, 45, 14, 0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset threshold
      queue_request(make_request(MODE_COUNTER, 1'b0, 8'h00, '0, '0, '0, '0, 6'd0));
      // first begin: no wake check yet
      queue_request(make_request(MODE_BEGIN, 1'b0, 8'h00, '0, '0, '0, 32'd200, '0));
      // end without begin, elapsed from zero, top bucket clamp
      queue_request(make_request(MODE_END, 1'b1, 8'hFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
                                 32'h8000_0000, 32'hFFFF_FFFF, 6'h3F));
      queue_request(make_request(MODE_END, 1'b0, 8'h01, '0, '0, 32'h7FFF_FFFF, 32'd201, '0));
      // gap just over the threshold wakes
      queue_request(make_request(MODE_BEGIN, 1'b0, 8'h5A, 48'h1234_5678_9ABC, 16'h0010,
                                 '0, 32'd302, '0));
      queue_request(make_request(MODE_END, 1'b0, 8'h5A, '0, 16'h0008, 32'hFFFF_FFFF,
                                 32'd302, '0));
      // gap equal to the threshold does not wake
      queue_request(make_request(MODE_BEGIN, 1'b1, 8'h80, 48'd5, 16'd3, '0, 32'd402, '0));
      queue_request(make_request(MODE_END, 1'b1, 8'h80, 48'd5, 16'd3, 32'd1, 32'd405, '0));
      queue_request(make_request(MODE_BEGIN, 1'b1, 8'h81, 48'd8, 16'd16, '0, 32'd600, '0));
      queue_request(make_request(MODE_END, 1'b1, 8'h81, 48'd8, 16'd16, 32'hFFFF_FFFE,
                                 32'd600 + 32'h0010_0000, '0));
      // mode three is dropped
      queue_request(make_request(MODE_NONE, 1'b1, 8'hFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F));
      foreach (read_list[i])
         queue_request(make_request(MODE_COUNTER, 1'b0, 8'h00, '0, '0, '0, '0, read_list[i]));
      wait_idle();

      // random phases, the sender holds off at each boundary until drained
      for (int p = 0; p < 5; p++) begin
         send_idle_pct = send_mix[p];
         recv_stall_pct = recv_mix[p];
         write_threshold(thresholds[p]);
         queue_random_traffic(PHASE_ITEMS);
         wait_idle();
      end

      $display("tb: %0d requests accepted: %0d begins, %0d ends, %0d counter reads, %0d dropped",
               accepted_total, mode_tally[MODE_BEGIN], mode_tally[MODE_END],
               mode_tally[MODE_COUNTER], mode_tally[MODE_NONE]);
      $display("tb: %0d records checked, %0d wakes, %0d threshold settings, %0d mismatches",
               records_checked, wake_records, settings_used, mismatches);
      if (mismatches == 0 && expected_records.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- storage_latency_histogram_monitor_core.f -----
+incdir+src
src/slhm_pkg.sv
src/slhm_hist_mem.sv
src/slhm_out_fifo.sv
src/storage_latency_histogram_monitor_core.sv
src/slhm_checker.sv
test/storage_latency_histogram_monitor_core_tb.sv
